// ----- hdl/rmc_pkg.sv -----
// Shared types, constants and header lookup for the RMC field extractor.
package rmc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned FID_W   = 4;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned POS_W   = 3;

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
	localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
	localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
	localparam logic [BYTE_W-1:0] CH_C      = 8'h43;

	localparam logic [POS_W-1:0] HDR_LEN    = 3'd5;
	localparam logic [FID_W-1:0] LAST_FIELD = 4'd8;
	localparam logic [FID_W-1:0] FID_LAT_HEMI = 4'd3;
	localparam logic [FID_W-1:0] FID_LON_HEMI = 4'd5;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_MATCH,
		PH_COMMA,
		PH_BODY,
		PH_SWALLOW
	} rmc_phase_t;

	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] ch;
		logic [FID_W-1:0]  fid;
		logic              eop;
		logic              ovf;
	} rmc_res_t;

	function automatic logic [BYTE_W-1:0] hdr_char(input logic [POS_W-1:0] pos);
		logic [BYTE_W-1:0] c;
		case (pos)
			3'd0:    c = CH_G;
			3'd1:    c = CH_P;
			3'd2:    c = CH_R;
			3'd3:    c = CH_M;
			3'd4:    c = CH_C;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/nmea_rmc_field_extractor_unit.sv -----
// Top level of the RMC field extractor: input register, parser and result register.
// Input register: a byte enters it when accepted; the parser forms its result combinationally,
// and that result enters the result register when the byte advances, which a held result can delay.
// Throughput: one byte per cycle; the input stalls only while a byte that makes a result
// waits behind a held result with out_ready low.
// Reset: arst_n clears both register stages and returns the parser to the '$' hunt.
module nmea_rmc_field_extractor_unit #(
	parameter int unsigned MAX_LEN = 80
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [rmc_pkg::BYTE_W-1:0] rx_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rmc_pkg::BYTE_W-1:0] char_out,
	output logic [rmc_pkg::FID_W-1:0]  field_id,
	output logic                       sentence_end,
	output logic                       overflow
);
	import rmc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;
	rmc_res_t          res;
	logic              out_valid_q;
	rmc_res_t          out_q;

	assign adv      = valid_s1 && (!res.vld || !out_valid_q || out_ready);
	assign rx_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			byte_s1 <= rx_byte;
	end

	rmc_core #(
		.MAX_LEN(MAX_LEN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_in (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.vld)
			out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign char_out     = out_q.ch;
	assign field_id     = out_q.fid;
	assign sentence_end = out_q.eop;
	assign overflow     = out_q.ovf;

	a_fid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.fid <= LAST_FIELD))
		else $error("field_id out of range");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.eop) |-> (out_q.ch == '0 && out_q.fid == '0))
		else $error("end transaction carries data");

	a_ovf_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ovf) |-> out_q.eop)
		else $error("overflow without sentence end");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> (valid_s1 && res.vld && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

endmodule

// ----- hdl/rmc_core.sv -----
// Sentence state machine: header match, field split and per-byte result.
module rmc_core #(
	parameter int unsigned MAX_LEN = 80
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic [rmc_pkg::BYTE_W-1:0] byte_in,
	output rmc_pkg::rmc_res_t       res
);
	import rmc_pkg::*;

	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 2);

	rmc_phase_t         phase_q, phase_d;
	logic [POS_W-1:0]   match_q, match_d;
	logic [FID_W-1:0]   field_q, field_d;
	logic               first_q, first_d;
	logic [LEN_W-1:0]   len_q, len_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			match_q <= '0;
			field_q <= '0;
			first_q <= 1'b1;
			len_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			match_q <= match_d;
			field_q <= field_d;
			first_q <= first_d;
			len_q   <= len_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		field_d = field_q;
		first_d = first_q;
		len_d   = len_q;
		res     = '0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_in == CH_DOLLAR) begin
					phase_d = PH_MATCH;
					match_d = '0;
				end
			end
			PH_MATCH: begin
				if (match_q < HDR_LEN && byte_in == hdr_char(match_q)) begin
					if (match_q == HDR_LEN - 3'd1) begin
						match_d = '0;
						phase_d = PH_COMMA;
					end else begin
						match_d = match_q + 3'd1;
					end
				end else begin
					match_d = '0;
					phase_d = PH_HUNT;
				end
			end
			PH_COMMA: begin
				field_d = '0;
				first_d = 1'b1;
				len_d   = '0;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (byte_in == CH_CR) begin
					res.vld = 1'b1;
					res.eop = 1'b1;
					phase_d = PH_SWALLOW;
				end else if (len_q >= LEN_LIMIT) begin
					res.vld = 1'b1;
					res.eop = 1'b1;
					res.ovf = 1'b1;
					phase_d = PH_HUNT;
					field_d = '0;
					first_d = 1'b1;
					len_d   = '0;
				end else begin
					len_d = len_q + 7'd1;
					if (byte_in == CH_COMMA) begin
						if (field_q <= LAST_FIELD)
							field_d = field_q + 4'd1;
						first_d = 1'b1;
					end else begin
						if (field_q <= LAST_FIELD &&
						    (first_q || (field_q != FID_LAT_HEMI &&
						                 field_q != FID_LON_HEMI))) begin
							res.vld = 1'b1;
							res.ch  = byte_in;
							res.fid = field_q;
						end
						first_d = 1'b0;
					end
				end
			end
			PH_SWALLOW: begin
				phase_d = PH_HUNT;
				field_d = '0;
				first_d = 1'b1;
				len_d   = '0;
			end
			default: begin
				phase_d = PH_HUNT;
				match_d = '0;
				field_d = '0;
				first_d = 1'b1;
				len_d   = '0;
			end
		endcase
	end

endmodule

// ----- sim/nmea_rmc_field_checker.sv -----
// Channel monitor, RMC field predictor and result comparison for the field extractor.
module nmea_rmc_field_checker #(
	parameter int unsigned MAX_LEN = 80
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	input  logic                       rx_ready,
	input  logic [rmc_pkg::BYTE_W-1:0] rx_byte,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [rmc_pkg::BYTE_W-1:0] char_out,
	input  logic [rmc_pkg::FID_W-1:0]  field_id,
	input  logic                       sentence_end,
	input  logic                       overflow,
	output int                         errors,
	output int                         pending,
	output int                         results,
	output int                         sentences,
	output int                         overflows
);
	import rmc_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic [FID_W-1:0]  fid;
		logic              eop;
		logic              ovf;
	} field_item_t;

	localparam logic [5*BYTE_W-1:0] RMC_TAG = {CH_G, CH_P, CH_R, CH_M, CH_C};

	rmc_phase_t        phase;
	logic [POS_W-1:0]  tag_pos;
	logic [FID_W-1:0]  cur_field;
	logic              field_fresh;
	logic [LEN_W-1:0]  body_len;
	field_item_t       expected_fields[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("checker: %s: got %0h, expected %0h, at result %0d", what, got, want,
			results);
		errors++;
	endtask

	task automatic restart_body();
		cur_field   = '0;
		field_fresh = 1'b1;
		body_len    = '0;
	endtask

	task automatic push_field(input logic [BYTE_W-1:0] ch, input logic [FID_W-1:0] fid,
			input logic eop, input logic ovf);
		field_item_t item;
		item.ch  = ch;
		item.fid = fid;
		item.eop = eop;
		item.ovf = ovf;
		expected_fields.push_back(item);
	endtask

	task automatic predict_rmc_byte(input logic [BYTE_W-1:0] b);
		int sh;
		case (phase)
			PH_HUNT: begin
				if (b == CH_DOLLAR) begin
					phase   = PH_MATCH;
					tag_pos = '0;
				end
			end
			PH_MATCH: begin
				sh = BYTE_W * (int'(HDR_LEN) - 1 - int'(tag_pos));
				if (tag_pos < HDR_LEN && b == RMC_TAG[sh +: BYTE_W]) begin
					tag_pos = tag_pos + 3'd1;
					if (tag_pos == HDR_LEN) begin
						tag_pos = '0;
						phase   = PH_COMMA;
					end
				end else begin
					tag_pos = '0;
					phase   = PH_HUNT;
				end
			end
			PH_COMMA: begin
				restart_body();
				phase = PH_BODY;
			end
			PH_BODY: begin
				if (b == CH_CR) begin
					push_field('0, '0, 1'b1, 1'b0);
					phase = PH_SWALLOW;
				end else if (int'(body_len) + 2 >= int'(MAX_LEN)) begin
					push_field('0, '0, 1'b1, 1'b1);
					phase = PH_HUNT;
					restart_body();
				end else begin
					body_len = body_len + 7'd1;
					if (b == CH_COMMA) begin
						if (cur_field <= LAST_FIELD)
							cur_field = cur_field + 4'd1;
						field_fresh = 1'b1;
					end else begin
						if (cur_field <= LAST_FIELD && (field_fresh ||
								!(cur_field == FID_LAT_HEMI || cur_field == FID_LON_HEMI)))
							push_field(b, cur_field, 1'b0, 1'b0);
						field_fresh = 1'b0;
					end
				end
			end
			PH_SWALLOW: begin
				phase = PH_HUNT;
				restart_body();
			end
			default: begin
				phase   = PH_HUNT;
				tag_pos = '0;
				restart_body();
			end
		endcase
	endtask

	task automatic check_field_item();
		field_item_t want;
		if (expected_fields.size() == 0) begin
			report_mismatch("result with nothing expected",
				32'({char_out, field_id, sentence_end, overflow}), '0);
		end else begin
			want = expected_fields.pop_front();
			if (char_out !== want.ch)
				report_mismatch("char_out", 32'(char_out), 32'(want.ch));
			if (field_id !== want.fid)
				report_mismatch("field_id", 32'(field_id), 32'(want.fid));
			if (sentence_end !== want.eop)
				report_mismatch("sentence_end", 32'(sentence_end), 32'(want.eop));
			if (overflow !== want.ovf)
				report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
			if (want.eop)
				sentences++;
			if (want.ovf)
				overflows++;
		end
		results++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase   = PH_HUNT;
			tag_pos = '0;
			restart_body();
			expected_fields.delete();
			errors    = 0;
			results   = 0;
			sentences = 0;
			overflows = 0;
		end else begin
			if (out_valid && out_ready)
				check_field_item();
			if (rx_valid && rx_ready)
				predict_rmc_byte(rx_byte);
		end
		pending = expected_fields.size();
	end

endmodule

// ----- sim/nmea_rmc_field_extractor_unit_test.sv -----
// Testbench top for the RMC field extractor: byte stimulus, handshake pacing and verdict.
module nmea_rmc_field_extractor_unit_test;
	import rmc_pkg::*;

	localparam int unsigned MAX_LEN = 80;
	localparam int IDLE_LIMIT  = 4000;
	localparam int ITEM_TARGET = 1350;

	logic              clk;
	logic              arst_n;
	logic              rx_valid;
	logic              rx_ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_ready;
	logic [BYTE_W-1:0] char_out;
	logic [FID_W-1:0]  field_id;
	logic              sentence_end;
	logic              overflow;

	int errors;
	int pending;
	int results;
	int sentences;
	int overflows;
	int bytes_sent;
	int burst_left;

	nmea_rmc_field_extractor_unit #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.field_id(field_id),
		.sentence_end(sentence_end),
		.overflow(overflow)
	);

	nmea_rmc_field_checker #(
		.MAX_LEN(MAX_LEN)
	) field_check (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.field_id(field_id),
		.sentence_end(sentence_end),
		.overflow(overflow),
		.errors(errors),
		.pending(pending),
		.results(results),
		.sentences(sentences),
		.overflows(overflows)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			rx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [BYTE_W-1:0] body_char();
		string pool;
		logic [BYTE_W-1:0] b;
		pool = "0123456789.NSEWAV";
		if ($urandom_range(0, 9) < 7) begin
			b = pool[$urandom_range(0, pool.len() - 1)];
		end else begin
			b = 8'($urandom);
			if (b == CH_CR || b == CH_COMMA)
				b = CH_DOLLAR;
		end
		return b;
	endfunction

	task automatic send_sentence();
		int field_cnt;
		int field_len;
		int long_len;
		send_text("$GPRMC");
		send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : CH_COMMA);
		if ($urandom_range(0, 14) == 0) begin
			long_len = $urandom_range(MAX_LEN - 5, MAX_LEN + 3);
			repeat (long_len)
				send_byte(($urandom_range(0, 7) == 0) ? CH_COMMA : body_char());
		end else begin
			field_cnt = $urandom_range(1, 13);
			for (int f = 0; f < field_cnt; f++) begin
				if (f != 0)
					send_byte(CH_COMMA);
				field_len = $urandom_range(0, 5);
				repeat (field_len)
					send_byte(body_char());
			end
		end
		send_byte(CH_CR);
		send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h0A);
	endtask

	task automatic send_broken_header();
		string tag;
		int good;
		tag  = "GPRMC";
		good = $urandom_range(0, 4);
		send_byte(CH_DOLLAR);
		for (int i = 0; i < good; i++)
			send_byte(tag[i]);
		send_byte(($urandom_range(0, 2) == 0) ? CH_DOLLAR : 8'($urandom));
	endtask

	initial begin : sink
		int mode;
		int span;
		out_ready = 1'b0;
		@(posedge arst_n);
		repeat (300) begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 3) != 0);
		end
		@(negedge clk);
		out_ready <= 1'b0;
		repeat (150)
			@(negedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((rx_valid && rx_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("no transaction for %0d cycles", IDLE_LIMIT);
		$display("nmea_rmc_field_extractor_unit: mismatch");
		$finish;
	end

	initial begin : source
		int kind;
		int useful;
		int mark;
		arst_n     = 1'b0;
		rx_valid   = 1'b0;
		rx_byte    = '0;
		bytes_sent = 0;
		burst_left = 0;
		useful     = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("$G$");
		send_text("$GPRMC,1,A,,NS,");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_DOLLAR);
		send_byte(CH_CR);
		send_byte(8'h0A);

		while (useful < ITEM_TARGET) begin
			kind = $urandom_range(0, 19);
			if (kind < 15) begin
				mark = bytes_sent;
				send_sentence();
				useful += bytes_sent - mark;
			end else if (kind < 18) begin
				send_broken_header();
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom));
			end
		end
		rx_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d bytes; checked %0d field characters and %0d sentence ends",
			bytes_sent, results - sentences, sentences);
		$display("%0d sentences were cut off at the length limit", overflows);
		if (errors == 0)
			$display("nmea_rmc_field_extractor_unit: match");
		else
			$display("nmea_rmc_field_extractor_unit: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/rmc_pkg.sv
hdl/rmc_core.sv
hdl/nmea_rmc_field_extractor_unit.sv
sim/nmea_rmc_field_checker.sv
sim/nmea_rmc_field_extractor_unit_test.sv
